// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define PCC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCC_ASSERT(label, prop)
`define PCC_ASSERT_IMPLY(label, ante, cons)
`define PCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, constants and byte functions for the PNG chunk extract/check block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pcc_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       done_res;
    logic [1:0] status;
  } pcc_out_t;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StMissing  = 2'd2;
  localparam logic [1:0] StCrcError = 2'd3;

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes     = 32'hFFFF_FFFF;
  localparam logic [31:0] IhdrDataLen = 32'd13;
  localparam logic [31:0] TargetReset = 32'h7074_464E;
  localparam logic [5:0]  HdrEnd      = 6'd41;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h49;
      2'd1:    v = 8'h48;
      2'd2:    v = 8'h44;
      default: v = 8'h52;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcc_in_stage.sv =====
// ----------------------------------------------------------------------------
// pcc_in_stage
// Input register: takes one request per cycle unless stalled, holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_in_stage import pcc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire pcc_in_t in_data_i,
  input  wire logic    take_i,
  output logic         s1_valid_o,
  output pcc_in_t      s1_data_o
);

  logic    valid_q;
  pcc_in_t data_q;

  assign in_stall_o = valid_q & ~take_i;
  assign s1_valid_o = valid_q;
  assign s1_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcc_parse.sv =====
// ----------------------------------------------------------------------------
// pcc_parse
// Header checks, chunk tracking, CRC-32 update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcc_parse import pcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] target_i,
  input  wire logic        s1_valid_i,
  input  wire pcc_in_t     s1_data_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pcc_out_t         out_data_o
);

  logic [5:0]  pos_q,  pos_d;
  logic [1:0]  herr_q, herr_d;
  logic [31:0] len_q,  len_d;
  logic [32:0] rem_q,  rem_d;
  logic [31:0] crc_q,  crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic        cmpl_q, cmpl_d;
  logic        out_valid_q;
  pcc_out_t    out_q, res;
  logic [7:0]  b;
  logic [1:0]  tidx;
  logic        step;

  assign take_o      = ~(out_valid_q & out_stall_i);
  assign step        = take_o & s1_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = s1_data_i.data_byte;
  assign tidx        = 2'(6'd40 - pos_q);

  always_comb begin
    pos_d  = pos_q;
    herr_d = herr_q;
    len_d  = len_q;
    rem_d  = rem_q;
    crc_d  = crc_q;
    scrc_d = scrc_q;
    cmpl_d = cmpl_q;
    res    = '0;

    if (pos_q < 6'd8) begin
      if (b != sig_byte(pos_q[2:0]) && herr_d == StOk) herr_d = StInvalid;
    end else if (pos_q < 6'd12) begin
      len_d = {len_q[23:0], b};
      if (pos_q == 6'd11 && len_d != IhdrDataLen && herr_d == StOk) herr_d = StInvalid;
    end else if (pos_q < 6'd16) begin
      if (b != ihdr_byte(pos_q[1:0]) && herr_d == StOk) herr_d = StInvalid;
    end else if (pos_q < 6'd33) begin
      // rest of IHDR, unchecked
    end else if (pos_q < 6'd37) begin
      len_d = {len_q[23:0], b};
    end else if (pos_q < HdrEnd) begin
      if (b != target_i[{tidx, 3'b000} +: 8] && herr_d == StOk) herr_d = StMissing;
      crc_d = crc_byte(crc_q, b);
      if (pos_q == 6'd40) rem_d = {1'b0, len_q} + 33'd4;
    end else if (rem_q != 33'd0) begin
      if (rem_q > 33'd4) begin
        crc_d             = crc_byte(crc_q, b);
        res.payload_valid = (herr_q == StOk);
      end else begin
        scrc_d = {scrc_q[23:0], b};
      end
      rem_d = rem_q - 33'd1;
      if (rem_d == 33'd0) cmpl_d = 1'b1;
    end

    if (pos_q < HdrEnd) pos_d = pos_q + 6'd1;

    res.payload_byte = res.payload_valid ? b : 8'd0;
    res.done_res     = s1_data_i.last_byte;

    if (s1_data_i.last_byte) begin
      if (pos_q < 6'd40)                   res.status = StInvalid;
      else if (herr_d != StOk)             res.status = herr_d;
      else if (!cmpl_d)                    res.status = StInvalid;
      else if ((crc_d ^ CrcOnes) != scrc_d) res.status = StCrcError;
      else                                 res.status = StOk;
      pos_d  = '0;
      herr_d = StOk;
      len_d  = '0;
      rem_d  = '0;
      crc_d  = CrcOnes;
      scrc_d = '0;
      cmpl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      herr_q      <= StOk;
      len_q       <= '0;
      rem_q       <= '0;
      crc_q       <= CrcOnes;
      scrc_q      <= '0;
      cmpl_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) out_valid_q <= s1_valid_i;
      if (step) begin
        pos_q  <= pos_d;
        herr_q <= herr_d;
        len_q  <= len_d;
        rem_q  <= rem_d;
        crc_q  <= crc_d;
        scrc_q <= scrc_d;
        cmpl_q <= cmpl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  `PCC_ASSERT_NEXT(a_last_clears, step && s1_data_i.last_byte, pos_q == 6'd0 && crc_q == CrcOnes)
  `PCC_ASSERT_IMPLY(a_rem_after_hdr, rem_q != 33'd0, pos_q == HdrEnd)
  `PCC_ASSERT_IMPLY(a_cmpl_no_rem, cmpl_q, rem_q == 33'd0)
  `PCC_ASSERT_IMPLY(a_pv_clean, out_valid_q && out_q.payload_valid && !out_q.done_res,
                    pos_q == HdrEnd && herr_q == StOk)

endmodule

`default_nettype wire

// ===== rtl/png_custom_chunk_extract_check.sv =====
// Path: each accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; the CRC-32 byte update is unrolled (combinational).
// Reset (rst_ni low, asynchronous): parser state, CRC and valid flags cleared, target
// chunk type returns to its reset value. No clearing pass; bytes are taken right away.
// ----------------------------------------------------------------------------
// png_custom_chunk_extract_check
// Streams a PNG file, checks its header, extracts the wanted chunk, checks its CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module png_custom_chunk_extract_check import pcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pcc_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pcc_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] target_q;
  logic        s1_valid;
  pcc_in_t     s1_data;
  logic        take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  pcc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_data_o  (s1_data)
  );

  pcc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .s1_valid_i  (s1_valid),
    .s1_data_i   (s1_data),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== dv/png_custom_chunk_extract_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_custom_chunk_extract_check_tb
// Feeds whole PNG files a byte at a time, good ones and damaged ones, under
// random input gaps and output stalls, and checks every result against a
// byte-level parser and CRC-32 tracker kept in the bench.
// ----------------------------------------------------------------------------

module png_custom_chunk_extract_check_tb;
  import pcc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 650;
  localparam logic [63:0] PngSigWord = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] IhdrWord = 32'h4948_4452;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  pcc_in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_stall_o;
  logic out_valid_o;
  pcc_out_t out_data_o;
  logic cfg_ready_o;

  // parser state mirrored from the block
  logic [31:0] tgt_type;
  logic [5:0] hdr_pos;
  logic [1:0] hdr_err;
  logic [31:0] len_acc;
  logic [32:0] remain;
  logic [31:0] crc_acc;
  logic [31:0] crc_stored;
  logic chunk_done;

  pcc_out_t awaited_results[$];
  logic [7:0] file_q[$];
  int errors = 0;
  int sent_bytes = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  png_custom_chunk_extract_check uut (
    .clk_i(clk_i),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic void clear_parse_state();
    hdr_pos = '0;
    hdr_err = StOk;
    len_acc = '0;
    remain = '0;
    crc_acc = CrcOnes;
    crc_stored = '0;
    chunk_done = 1'b0;
  endfunction

  function automatic void file_add(input logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  function automatic void flag_header(input logic [1:0] code);
    if (hdr_err == StOk) hdr_err = code;
  endfunction

  task automatic predict_png_byte(input logic [7:0] b, input logic last);
    pcc_out_t r;
    int p;
    r = '0;
    p = int'(hdr_pos);
    if (p < 8) begin
      if (b != PngSigWord[8 * (7 - p) +: 8]) flag_header(StInvalid);
    end else if (p < 12) begin
      len_acc = {len_acc[23:0], b};
      if (p == 11 && len_acc != IhdrDataLen) flag_header(StInvalid);
    end else if (p < 16) begin
      if (b != IhdrWord[8 * (15 - p) +: 8]) flag_header(StInvalid);
    end else if (p < 33) begin
      // rest of IHDR is skipped
    end else if (p < 37) begin
      len_acc = {len_acc[23:0], b};
    end else if (p < HdrEnd) begin
      if (b != tgt_type[8 * (40 - p) +: 8]) flag_header(StMissing);
      crc_acc = crc_step(crc_acc, b);
      if (p == 40) remain = {1'b0, len_acc} + 33'd4;
    end else if (remain != 0) begin
      if (remain > 4) begin
        crc_acc = crc_step(crc_acc, b);
        if (hdr_err == StOk) begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
        end
      end else begin
        crc_stored = {crc_stored[23:0], b};
      end
      remain = remain - 33'd1;
      if (remain == 0) chunk_done = 1'b1;
    end
    if (p < HdrEnd) hdr_pos = 6'(p + 1);
    if (last) begin
      r.done_res = 1'b1;
      if (p < 40) r.status = StInvalid;
      else if (hdr_err != StOk) r.status = hdr_err;
      else if (!chunk_done) r.status = StInvalid;
      else if ((crc_acc ^ CrcOnes) != crc_stored) r.status = StCrcError;
      else r.status = StOk;
      clear_parse_state();
    end
    awaited_results.insert(awaited_results.size(), r);
  endtask

  // receive side: check each accepted result, then pick the next stall
  always @(posedge clk_i or negedge rst_n) begin : rx
    pcc_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result %p", out_data_o);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h",
                   want.payload_byte, out_data_o.payload_byte);
            errors++;
          end
          if (out_data_o.payload_valid !== want.payload_valid) begin
            $error("payload_valid: expected %0d, actual %0d",
                   want.payload_valid, out_data_o.payload_valid);
            errors++;
          end
          if (out_data_o.done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, out_data_o.done_res);
            errors++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic push_png_byte(input logic [7:0] b, input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_png_byte(b, last);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) push_png_byte(file_q[i], i == file_q.size() - 1);
    sent_bytes += file_q.size();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    tgt_type = v;
  endtask

  // well-formed file: signature, IHDR, then the chunk with a correct CRC
  task automatic build_png(input logic [31:0] ctype, input int plen);
    logic [31:0] c;
    logic [7:0] b;
    file_q.delete();
    for (int i = 7; i >= 0; i--) file_add(PngSigWord[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) file_add(IhdrDataLen[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) file_add(IhdrWord[8 * i +: 8]);
    for (int i = 0; i < 17; i++) file_add(8'($urandom));
    for (int i = 3; i >= 0; i--) file_add(8'(plen >> (8 * i)));
    c = CrcOnes;
    for (int i = 3; i >= 0; i--) begin
      file_add(ctype[8 * i +: 8]);
      c = crc_step(c, ctype[8 * i +: 8]);
    end
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      file_add(b);
      c = crc_step(c, b);
    end
    c = c ^ CrcOnes;
    for (int i = 3; i >= 0; i--) file_add(c[8 * i +: 8]);
  endtask

  task automatic truncate_file(input int n);
    while (file_q.size() > n) file_q.delete(file_q.size() - 1);
  endtask

  task automatic test_good_files();
    build_png(tgt_type, 0);
    send_file();
    build_png(tgt_type, 1);
    file_q[41] = 8'h00;
    file_q[42] = ~file_q[42];
    send_file();
    build_png(tgt_type, 7);
    send_file();
  endtask

  task automatic test_short_files();
    build_png(tgt_type, 0);
    truncate_file(1);
    send_file();
    build_png(tgt_type, 0);
    truncate_file(40);
    send_file();
    build_png(tgt_type, 0);
    truncate_file(41);
    send_file();
  endtask

  task automatic test_header_errors();
    build_png(tgt_type, 2);
    file_q[3] ^= 8'h01;
    send_file();
    build_png(tgt_type, 2);
    file_q[11] = 8'h0E;
    send_file();
    build_png(tgt_type, 2);
    file_q[8] = 8'h80;
    send_file();
    build_png(tgt_type, 2);
    file_q[14] ^= 8'h20;
    send_file();
    build_png(tgt_type, 2);
    file_q[39] ^= 8'h80;
    send_file();
    build_png(tgt_type, 2);
    file_q[0] = 8'hFF;
    file_q[37] ^= 8'h01;
    send_file();
  endtask

  task automatic test_chunk_truncation();
    build_png(tgt_type, 6);
    truncate_file(44);
    send_file();
    build_png(tgt_type, 6);
    truncate_file(49);
    send_file();
    build_png(tgt_type, 2);
    for (int i = 33; i < 37; i++) file_q[i] = 8'hFF;
    truncate_file(46);
    send_file();
  endtask

  task automatic test_crc_mismatch();
    build_png(tgt_type, 4);
    file_q[file_q.size() - 1] ^= 8'h01;
    send_file();
    build_png(tgt_type, 4);
    file_q[42] ^= 8'h80;
    send_file();
  endtask

  task automatic test_trailing_bytes();
    build_png(tgt_type, 3);
    repeat (5) file_add(8'($urandom));
    send_file();
  endtask

  task automatic test_target_register();
    write_target(32'h0000_0000);
    build_png(tgt_type, 2);
    send_file();
    write_target(32'hFFFF_FFFF);
    build_png(tgt_type, 2);
    send_file();
    write_target(32'h4944_4154);
    build_png(TargetReset, 2);
    send_file();
  endtask

  task automatic test_output_backpressure();
    drain_results();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    hold_cycles = 300;
    build_png(tgt_type, 250);
    send_file();
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_files();
    int files;
    int plen;
    int pick;
    int n;
    files = 0;
    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      if (files % 4 == 3) begin
        pick = $urandom_range(3);
        case (pick)
          0: write_target(32'h0000_0000);
          1: write_target(32'hFFFF_FFFF);
          2: write_target(TargetReset);
          default: write_target($urandom);
        endcase
      end
      gaps_on = !(files >= 3 && files < 8);
      stall_on = gaps_on;
      plen = ($urandom_range(9) == 0) ? $urandom_range(64, 160) : $urandom_range(0, 16);
      build_png(($urandom_range(9) == 0) ? $urandom : tgt_type, plen);
      pick = $urandom_range(99);
      if (pick < 60) begin
        // left intact
      end else if (pick < 68) begin
        n = $urandom_range(file_q.size() - 1);
        file_q[n] ^= 8'($urandom_range(1, 255));
      end else if (pick < 76) begin
        truncate_file($urandom_range(1, file_q.size() - 1));
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 8)) file_add(8'($urandom));
      end else if (pick < 90) begin
        file_q[file_q.size() - 1 - $urandom_range(3)] ^= 8'($urandom_range(1, 255));
      end else if (pick < 95) begin
        n = $urandom_range(1, 50);
        file_q.delete();
        repeat (n) file_add(8'($urandom));
      end else begin
        file_q[$urandom_range(15)] ^= 8'($urandom_range(1, 255));
      end
      send_file();
      files++;
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    tgt_type = TargetReset;
    clear_parse_state();
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_good_files();
    test_short_files();
    test_header_errors();
    test_chunk_truncation();
    test_crc_mismatch();
    test_trailing_bytes();
    test_target_register();
    test_output_backpressure();
    test_random_files();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
